>>> src/fbdt_pkg.sv
// fbdt_pkg: shared types, constants and helpers for the freezable delay tap.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fbdt_pkg;

    // Delay memory geometry (depth must be a power of two: pointer wraps by truncation)
    localparam int DELAY_DEPTH = 262144;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int LOOP_W    = 18;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int FRAC_W    = SAMPLE_W - 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = LOOP_W;
    localparam int CMP_W     = ((ADDR_W > LOOP_W) ? ADDR_W : LOOP_W) + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REINJECT_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE_MANUAL = 2'd2;

    // Reset values and thresholds
    localparam logic [LOOP_W-1:0]          LOOP_RESET       = 18'd4800;
    localparam logic signed [SAMPLE_W-1:0] GAIN_RESET       = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] FREEZE_THRESHOLD = 16'sd16384;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX       = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN       = -16'sd32768;

    // One access bundle towards the delay memory
    typedef struct packed {
        logic                       we;
        logic [ADDR_W-1:0]          waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic                       re;
        logic [ADDR_W-1:0]          raddr;
    } mem_req_t;

    // Tap distance clamped to 1..DELAY_DEPTH-1
    function automatic logic [ADDR_W-1:0] clamp_loop(input logic [LOOP_W-1:0] len);
        logic [CMP_W-1:0] lx;
        logic [CMP_W-1:0] res;
        lx  = CMP_W'(len);
        res = lx;
        if (lx == '0)
            res = CMP_W'(1);
        else if (lx > CMP_W'(DELAY_DEPTH - 1))
            res = CMP_W'(DELAY_DEPTH - 1);
        return res[ADDR_W-1:0];
    endfunction

endpackage

>>> src/fbdt_delay_mem.sv
// fbdt_delay_mem: single-port-write, single-port-read delay sample store.
// Depends on fbdt_pkg (geometry, mem_req_t). Read data is registered.
`timescale 1ns / 1ps

module fbdt_delay_mem
    import fbdt_pkg::*;
(
    input  logic                       clk,
    input  mem_req_t                   req,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fbdt_mix.sv
// fbdt_mix: tap gain multiply and saturating mix, two register stages.
// Depends on fbdt_pkg. Stage 1 lines up with the memory read data.
`timescale 1ns / 1ps

module fbdt_mix
    import fbdt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] dry,
    input  logic                       tap_ok,
    input  logic signed [SAMPLE_W-1:0] tap_data,
    input  logic signed [SAMPLE_W-1:0] gain,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] mixed
);

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_dry_reg;
    logic                       s1_tap_ok_reg;
    logic                       s2_valid_reg;
    logic signed [SAMPLE_W-1:0] s2_dry_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;

    logic signed [SAMPLE_W-1:0] tapped;
    logic signed [PROD_W-1:0]   s2_prod_next;
    logic signed [PROD_W-FRAC_W-1:0] scaled;
    logic signed [PROD_W-FRAC_W:0]   sum;

    // never-written entries read as zero
    assign tapped       = s1_tap_ok_reg ? tap_data : '0;
    assign s2_prod_next = gain * tapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dry_reg    <= dry;
            s1_tap_ok_reg <= tap_ok;
            s2_dry_reg    <= s1_dry_reg;
            s2_prod_reg   <= s2_prod_next;
        end
    end

    // floor(prod / 2^15), then add and clip
    assign scaled = s2_prod_reg[PROD_W-1:FRAC_W];
    assign sum    = (PROD_W-FRAC_W+1)'(s2_dry_reg) + (PROD_W-FRAC_W+1)'(scaled);

    always_comb
    begin
        if (sum > (PROD_W-FRAC_W+1)'(SAMPLE_MAX))
            mixed = SAMPLE_MAX;
        else if (sum < (PROD_W-FRAC_W+1)'(SAMPLE_MIN))
            mixed = SAMPLE_MIN;
        else
            mixed = sum[SAMPLE_W-1:0];
    end

    assign out_valid = s2_valid_reg;

endmodule

>>> src/fbdt_out_buf.sv
// fbdt_out_buf: two-entry output buffer that decouples the pipeline stall from tready.
// Depends on fbdt_pkg for the sample width.
`timescale 1ns / 1ps

module fbdt_out_buf
    import fbdt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_data,
    output logic                       space,
    output logic                       tvalid,
    input  logic                       tready,
    output logic signed [SAMPLE_W-1:0] tdata
);

    logic [1:0]                 count_reg, count_next;
    logic signed [SAMPLE_W-1:0] slot0_reg, slot0_next;
    logic signed [SAMPLE_W-1:0] slot1_reg, slot1_next;
    logic                       pop;

    assign pop    = tvalid && tready;
    assign tvalid = (count_reg != 2'd0);
    assign tdata  = slot0_reg;
    assign space  = (count_reg != 2'd2);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    slot0_next = push_data;
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                    count_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> src/freezable_feedback_delay_tap_core.sv
// freezable_feedback_delay_tap_core: top level of the freezable delay tap.
// Depends on fbdt_pkg, fbdt_delay_mem, fbdt_mix and fbdt_out_buf.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one beat per audio sample, dry sample and freeze control.
//   Master stream (m_*): one beat per accepted input, the mixed sample.
//   cfg_*: plain write port; write only while the block is idle.
// Throughput: one beat per cycle sustained when not stalled. The tap read and the
//   sample write use separate ports of the delay memory in the accept cycle; the
//   read address always trails the write pointer by at least one, so they never meet.
// Path: an accepted beat passes the registered memory read, the multiply and the
//   mix into the output buffer before it appears on m_tdata.
// Stall: the output buffer holds two beats; while it is full the whole pipeline
//   freezes and s_tready drops. s_tready never depends on m_tready combinationally.
// Reset: pointer to zero, registers to their defaults, pipeline emptied.
//   No clearing pass: until the pointer first wraps, taps behind address zero
//   read as zero, and frozen beats in that first lap write zero, so the memory
//   behaves as if cleared at reset. The block is ready straight after reset.
module freezable_feedback_delay_tap_core
    import fbdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] dry_sample, [31:16] freeze_control
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] mixed_sample
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [LOOP_W-1:0]          loop_length_reg;
    logic signed [SAMPLE_W-1:0] reinject_gain_reg;
    logic                       freeze_manual_reg;

    logic [ADDR_W-1:0]          wp_reg, wp_next;
    logic                       wrapped_reg, wrapped_next;

    logic                       en;
    logic                       accept;
    logic signed [SAMPLE_W-1:0] dry_sample;
    logic signed [SAMPLE_W-1:0] freeze_control;
    logic                       freeze;
    logic [ADDR_W-1:0]          loop_eff;
    logic                       tap_ok;
    mem_req_t                   mem_req;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    logic                       mix_valid;
    logic signed [SAMPLE_W-1:0] mix_data;
    logic signed [SAMPLE_W-1:0] out_data;

    assign dry_sample     = s_tdata[15:0];
    assign freeze_control = s_tdata[31:16];

    // pipeline advances whenever the output buffer has room
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_length_reg   <= LOOP_RESET;
            reinject_gain_reg <= GAIN_RESET;
            freeze_manual_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOOP_LENGTH:   loop_length_reg   <= cfg_wdata[LOOP_W-1:0];
                REG_REINJECT_GAIN: reinject_gain_reg <= cfg_wdata[SAMPLE_W-1:0];
                REG_FREEZE_MANUAL: freeze_manual_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // address generation
    assign loop_eff = clamp_loop(loop_length_reg);
    assign freeze   = freeze_manual_reg || (freeze_control >= FREEZE_THRESHOLD);
    // tap is live once the pointer has wrapped, or if it lies ahead of address zero
    assign tap_ok   = wrapped_reg || (wp_reg >= loop_eff);

    always_comb
    begin
        mem_req.re    = en;
        mem_req.raddr = wp_reg - loop_eff;
        mem_req.waddr = wp_reg;
        // first lap: a frozen beat still stores zero, the cleared value
        mem_req.we    = accept && (!freeze || !wrapped_reg);
        mem_req.wdata = freeze ? '0 : dry_sample;
    end

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (accept)
        begin
            wp_next = wp_reg + 1'b1;
            if (wp_reg == ADDR_W'(DELAY_DEPTH - 1))
                wrapped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
        end
    end

    fbdt_delay_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    fbdt_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .dry       (dry_sample),
        .tap_ok    (tap_ok),
        .tap_data  (mem_rdata),
        .gain      (reinject_gain_reg),
        .out_valid (mix_valid),
        .mixed     (mix_data)
    );

    fbdt_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mix_valid && en),
        .push_data (mix_data),
        .space     (en),
        .tvalid    (m_tvalid),
        .tready    (m_tready),
        .tdata     (out_data)
    );

    assign m_tdata = out_data;

`ifndef SYNTHESIS
    // tap read and sample write never hit the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.raddr != mem_req.waddr))
        else $error("delay memory read and write collide");

    // pointer moves by exactly one per accepted beat
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance");

    // pointer holds when no beat is accepted
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(wp_reg))
        else $error("write pointer moved without a beat");

    // a stalled pipeline takes no new beat
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> !accept && !mem_req.we)
        else $error("beat taken while output buffer full");
`endif

endmodule

>>> tb/sv/fbdt_tap_monitor.sv
// fbdt_tap_monitor: watches the stream and config ports of the delay tap, predicts
// every mixed sample from its own copy of the delay memory and compares results.
// Depends on fbdt_pkg for widths, register indexes and saturation limits.
`timescale 1ns / 1ps

module fbdt_tap_monitor
    import fbdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] dry_sample, [31:16] freeze_control
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // [15:0] mixed_sample
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    n_fail,
    output int                    n_pending
);

    logic [SAMPLE_W-1:0]        tap_mem [DELAY_DEPTH];
    logic [ADDR_W-1:0]          wr_ptr;
    logic [LOOP_W-1:0]          loop_len;
    logic signed [SAMPLE_W-1:0] gain;
    logic                       freeze_man;
    logic [SAMPLE_W-1:0]        mixed_q [$];
    int                         n_results;

    initial
    begin
        n_fail    = 0;
        n_pending = 0;
        n_results = 0;
    end

    // distance behind the write pointer, held inside 1..DELAY_DEPTH-1
    function automatic logic [ADDR_W-1:0] tap_distance(input logic [LOOP_W-1:0] len);
        if (len == '0)
            return ADDR_W'(1);
        if (longint'(len) > longint'(DELAY_DEPTH - 1))
            return ADDR_W'(DELAY_DEPTH - 1);
        return ADDR_W'(len);
    endfunction

    // dry + floor(gain * tapped / 2^15), saturated to 16 bits
    function automatic logic [SAMPLE_W-1:0] mix_tap(input logic signed [SAMPLE_W-1:0] dry,
                                                    input logic signed [SAMPLE_W-1:0] tapped,
                                                    input logic signed [SAMPLE_W-1:0] g);
        logic signed [31:0] prod;
        logic signed [31:0] sum;
        prod = g * tapped;
        sum  = dry + (prod >>> FRAC_W);
        if (sum > SAMPLE_MAX)
            sum = SAMPLE_MAX;
        if (sum < SAMPLE_MIN)
            sum = SAMPLE_MIN;
        return sum[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [ADDR_W-1:0]   rd_addr;
        logic [SAMPLE_W-1:0] want;
        logic [SAMPLE_W-1:0] dry;
        logic [SAMPLE_W-1:0] ctrl;
        if (!rst_n)
        begin
            for (int i = 0; i < DELAY_DEPTH; i++)
                tap_mem[i] = '0;
            wr_ptr     = '0;
            loop_len   = LOOP_RESET;
            gain       = GAIN_RESET;
            freeze_man = 1'b0;
            mixed_q.delete();
            n_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOOP_LENGTH:   loop_len   = cfg_wdata[LOOP_W-1:0];
                    REG_REINJECT_GAIN: gain       = cfg_wdata[SAMPLE_W-1:0];
                    REG_FREEZE_MANUAL: freeze_man = cfg_wdata[0];
                    default:           ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (mixed_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: result beat %0d (%h) with no sample in flight",
                                 $realtime, n_results, m_tdata);
                end
                else
                begin
                    want = mixed_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("%0t: mixed_sample beat %0d expected %0d (%h) got %0d (%h)",
                                     $realtime, n_results, $signed(want), want,
                                     $signed(m_tdata), m_tdata);
                    end
                end
                n_results++;
            end

            if (s_tvalid && s_tready)
            begin
                dry     = s_tdata[15:0];
                ctrl    = s_tdata[31:16];
                rd_addr = wr_ptr - tap_distance(loop_len);
                mixed_q.push_back(mix_tap(dry, tap_mem[rd_addr], gain));
                // freeze: manual bit or control at 0.5 and above; pointer moves regardless
                if (!(freeze_man || ($signed(ctrl) >= FREEZE_THRESHOLD)))
                    tap_mem[wr_ptr] = dry;
                wr_ptr = wr_ptr + 1'b1;
            end

            n_pending <= mixed_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// tb: stimulus and verdict for freezable_feedback_delay_tap_core.
// Depends on fbdt_pkg, the core RTL and fbdt_tap_monitor (prediction and compare).
`timescale 1ns / 1ps

module tb
    import fbdt_pkg::*;
();

    // index with no register behind it; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int  DRAIN_CYCLES = 12;     // comfortably beyond the pipeline latency
    localparam int  LONG_HOLD    = 80;     // receiver hold-off, far longer than the buffering
    localparam int  PHASE_BEATS  = 240;
    localparam int  WIDE_BEATS   = 120;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [15:0] dry_sample, [31:16] freeze_control
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [15:0] mixed_sample
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   n_fail;
    int   n_pending;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    bit   hold_taken    = 1'b0;
    int   hold_left     = 0;

    always #2 clk = ~clk;

    freezable_feedback_delay_tap_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fbdt_tap_monitor u_mon (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    // Receiver side: random back-pressure, plus one long hold-off on request.
    // The hold is counted here so the sender keeps offering beats meanwhile,
    // which fills the output buffer and should pull s_tready low.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Absolute ceiling on the run; a stuck handshake ends up here.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Audio samples: mostly random, now and then full scale either way
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(19))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    // Control samples: random, with extra weight on either side of the 0.5 threshold
    function automatic logic [15:0] pick_control();
        logic [15:0] v;
        case ($urandom_range(19))
            0:       v = 16'h3FFF;
            1:       v = 16'h4000;
            2:       v = 16'h0000;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    // One beat on the slave stream; returns at the edge that takes it
    task automatic push_beat(input logic [15:0] dry, input logic [15:0] ctrl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ctrl, dry};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted sample has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // All three registers plus a junk write to the spare index, idle block only.
    // Bits above each register's width are random and must be ignored.
    task automatic write_regs(input logic [LOOP_W-1:0] len, input logic [15:0] g,
                              input logic frz);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOOP_LENGTH;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_index <= REG_REINJECT_GAIN;
        cfg_wdata <= {2'($urandom()), g};
        @(posedge clk);
        cfg_index <= REG_FREEZE_MANUAL;
        cfg_wdata <= {17'($urandom()), frz};
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_wdata <= 18'($urandom());
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A phase of random beats under one random setting. Short taps dominate so
    // that most reads land on samples written a few beats earlier.
    task automatic run_random(input int n, input int pct_s, input int pct_r,
                              input bit wide_taps, input bit with_hold);
        logic [LOOP_W-1:0] len;
        logic [15:0]       g;
        int                pick;
        send_idle_pct = pct_s;
        recv_idle_pct = pct_r;
        pick = $urandom_range(99);
        if (wide_taps)
            len = 18'($urandom());
        else if (pick < 60)
            len = 18'($urandom_range(48, 1));
        else if (pick < 70)
            len = '0;
        else if (pick < 85)
            len = 18'($urandom_range(2000, 49));
        else
            len = '1;
        pick = $urandom_range(99);
        if (pick < 8)
            g = 16'h8000;
        else if (pick < 16)
            g = 16'h7FFF;
        else
            g = 16'($urandom());
        write_regs(len, g, ($urandom_range(99) < 20));
        for (int i = 0; i < n; i++)
        begin
            // one pause mid-phase until the pipeline has fully drained
            if (i == n / 2)
                settle();
            if (with_hold && i == 60)
                hold_req <= 1'b1;
            push_beat(pick_sample(), pick_control());
        end
        settle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // zero length clamps to one; gain -1.0: -1 x -1 gives +1.0 and saturates,
        // control at and just below 0.5, most negative control
        write_regs('0, 16'h8000, 1'b0);
        push_beat(16'h8000, 16'h0000);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h8000, 16'h4000);
        push_beat(16'h1234, 16'h3FFF);
        push_beat(16'h0000, 16'h7FFF);
        push_beat(16'hFFFF, 16'h8000);
        push_beat(16'h0005, 16'h0000);
        settle();
        // smallest gain on -1: product truncates towards minus infinity
        write_regs(18'd1, 16'h0001, 1'b0);
        push_beat(16'hFFFF, 16'h0000);
        push_beat(16'h0000, 16'h0000);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h0001, 16'h0000);
        settle();
        // manual freeze: nothing written whatever the control says
        write_regs(18'd1, 16'h7FFF, 1'b1);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h7FFF, 16'hC000);
        push_beat(16'hAAAA, 16'h5555);
        settle();
        // longest tap: reads just ahead of the pointer, still empty on the first lap
        write_regs('1, 16'h7FFF, 1'b0);
        push_beat(16'h5555, 16'h0000);
        push_beat(16'h8000, 16'h0000);
        settle();
        // sum overflow both ways with full-scale gain
        write_regs(18'd2, 16'h7FFF, 1'b0);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h7FFF, 16'h0000);
        push_beat(16'h8000, 16'h0000);
        push_beat(16'h8000, 16'h0000);
        push_beat(16'h8000, 16'h0000);
        settle();

        // --- random phases: receiver lazy, then sender lazy, then neither ---
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
                run_random(PHASE_BEATS, 26, 64, 1'b0, (ph == 0));
            else if (ph < 4)
                run_random(PHASE_BEATS, 64, 26, 1'b0, 1'b0);
            else
                run_random(PHASE_BEATS, 0, 0, 1'b0, 1'b0);
        end

        // taps of any length, mostly reaching entries not yet written
        run_random(WIDE_BEATS, 0, 0, 1'b1, 1'b0);
        run_random(WIDE_BEATS, 0, 0, 1'b1, 1'b0);

        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
